FILE: rtl/ffaa_pkg.sv
// shared types and constants of the first-fit arena allocator
package ffaa_pkg;

   localparam int ArenaBytes  = 256;
   localparam int HeaderBytes = 16;
   localparam int MaxBlocks   = 16;

   localparam int OFS_W = 9;
   localparam int LEN_W = 9;
   localparam int IDX_W = 4;
   localparam int CNT_W = 5;
   localparam int SUM_W = 10;

   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_FREE   = 2'd1;
   localparam logic [1:0] MODE_RESIZE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOSPACE   = 2'd1;
   localparam logic [1:0] ST_BADHANDLE = 2'd2;

   // one table entry as stored in the block memory
   typedef struct packed {
      logic [OFS_W-1:0] start;
      logic [LEN_W-1:0] length;
      logic             in_use;
   } entry_type;

   // memory port bundle from the sequencer
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

endpackage

FILE: rtl/ffaa_table_ram.sv
// block table memory: one write port, one registered read port
module ffaa_table_ram (
   input  logic                  clock,
   input  ffaa_pkg::mem_req_type mem_req,
   output ffaa_pkg::entry_type   rd_data
);

   ffaa_pkg::entry_type mem [ffaa_pkg::MaxBlocks];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data <= mem[mem_req.rd_addr];
   end

endmodule

FILE: rtl/ffaa_sequencer.sv
// request sequencer: lookup, compaction, first-fit scan and insertion
module ffaa_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [1:0]                    req_mode,
   input  logic [7:0]                    req_req_size,
   input  logic [ffaa_pkg::OFS_W-1:0]    req_handle,
   output logic                          busy,
   output logic                          rsp_valid,
   output logic [ffaa_pkg::OFS_W-1:0]    rsp_payload_offset,
   output logic [1:0]                    rsp_status,
   output ffaa_pkg::mem_req_type         mem_req,
   input  ffaa_pkg::entry_type           rd_data
);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_FIND    = 9'b000000010,
      S_FINDCHK = 9'b000000100,
      S_COMPACT = 9'b000001000,
      S_CMPCHK  = 9'b000010000,
      S_SCAN    = 9'b000100000,
      S_SCANCHK = 9'b001000000,
      S_SHIFT   = 9'b010000000,
      S_DONE    = 9'b100000000
   } state_type;

   localparam logic [ffaa_pkg::SUM_W-1:0] Hdr = ffaa_pkg::SUM_W'(ffaa_pkg::HeaderBytes);
   localparam logic [ffaa_pkg::SUM_W-1:0] Arena = ffaa_pkg::SUM_W'(ffaa_pkg::ArenaBytes);
   localparam logic [ffaa_pkg::CNT_W-1:0] Full = ffaa_pkg::CNT_W'(ffaa_pkg::MaxBlocks);

   state_type state_ff, state_in;
   logic [ffaa_pkg::CNT_W-1:0] count_ff, count_in;
   logic [ffaa_pkg::CNT_W-1:0] rptr_ff, rptr_in;   // read pointer
   logic [ffaa_pkg::CNT_W-1:0] wptr_ff, wptr_in;   // compaction write / insert pos
   logic [1:0] mode_ff, mode_in;
   logic [ffaa_pkg::SUM_W-1:0] need_ff, need_in;
   logic [ffaa_pkg::OFS_W-1:0] handle_ff, handle_in;
   logic [ffaa_pkg::SUM_W-1:0] end_ff, end_in;      // end of previous block in scan
   logic [ffaa_pkg::OFS_W-1:0] ofs_ff, ofs_in;
   logic [1:0] st_ff, st_in;
   logic valid_ff, valid_in;
   ffaa_pkg::entry_type carry_ff, carry_in;           // new entry to insert
   ffaa_pkg::mem_req_type mreq;

   // set in every ripple cycle after the first: rd_data holds the old entry below wptr
   logic shift_pending_ff;

   logic [ffaa_pkg::SUM_W-1:0] rd_end, rd_start_w;

   assign rd_start_w = ffaa_pkg::SUM_W'(rd_data.start);
   assign rd_end = rd_start_w + ffaa_pkg::SUM_W'(rd_data.length);

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = valid_ff;
   assign rsp_payload_offset = ofs_ff;
   assign rsp_status         = st_ff;
   assign mem_req            = mreq;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rptr_in   = rptr_ff;
      wptr_in   = wptr_ff;
      mode_in   = mode_ff;
      need_in   = need_ff;
      handle_in = handle_ff;
      end_in    = end_ff;
      ofs_in    = ofs_ff;
      st_in     = st_ff;
      carry_in  = carry_ff;
      valid_in  = 1'b0;
      mreq         = '0;
      mreq.rd_addr = rptr_ff[ffaa_pkg::IDX_W-1:0];
      mreq.wr_data = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in   = req_mode;
               need_in   = ffaa_pkg::SUM_W'(req_req_size) + Hdr;
               handle_in = req_handle;
               ofs_in    = '0;
               st_in     = ffaa_pkg::ST_OK;
               rptr_in   = '0;
               wptr_in   = '0;
               if (req_mode == ffaa_pkg::MODE_ALLOC ||
                   (req_mode == ffaa_pkg::MODE_RESIZE && req_handle == '0)) begin
                  state_in = S_COMPACT;
               end else if ((req_mode == ffaa_pkg::MODE_FREE ||
                             req_mode == ffaa_pkg::MODE_RESIZE) && req_handle != '0) begin
                  state_in = S_FIND;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_FIND: begin
            if (rptr_ff >= count_ff) begin
               st_in    = ffaa_pkg::ST_BADHANDLE;
               state_in = S_DONE;
            end else begin
               state_in = S_FINDCHK;
            end
         end
         S_FINDCHK: begin
            if (rd_data.in_use &&
                ffaa_pkg::SUM_W'(rd_data.start) + Hdr == ffaa_pkg::SUM_W'(handle_ff)) begin
               mreq.wr_en   = 1'b1;
               mreq.wr_addr = rptr_ff[ffaa_pkg::IDX_W-1:0];
               if (mode_ff == ffaa_pkg::MODE_RESIZE &&
                   ffaa_pkg::SUM_W'(rd_data.length) >= need_ff) begin
                  mreq.wr_data.length = need_ff[ffaa_pkg::LEN_W-1:0];
                  ofs_in   = handle_ff;
                  state_in = S_DONE;
               end else begin
                  mreq.wr_data.in_use = 1'b0;
                  if (mode_ff == ffaa_pkg::MODE_RESIZE) begin
                     rptr_in  = '0;
                     state_in = S_COMPACT;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end else begin
               rptr_in  = rptr_ff + 1'b1;
               state_in = S_FIND;
            end
         end
         S_COMPACT: begin
            if (rptr_ff >= count_ff) begin
               count_in = wptr_ff;
               rptr_in  = '0;
               end_in   = '0;
               if (wptr_ff == Full) begin
                  st_in    = ffaa_pkg::ST_NOSPACE;
                  state_in = S_DONE;
               end else if (wptr_ff == '0) begin
                  if (need_ff <= Arena) begin
                     wptr_in  = '0;
                     end_in   = '0;
                     state_in = S_SHIFT;
                     carry_in = '{start: '0, length: need_ff[ffaa_pkg::LEN_W-1:0],
                                  in_use: 1'b1};
                     ofs_in   = ffaa_pkg::OFS_W'(Hdr);
                  end else begin
                     st_in    = ffaa_pkg::ST_NOSPACE;
                     state_in = S_DONE;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               state_in = S_CMPCHK;
            end
         end
         S_CMPCHK: begin
            if (rd_data.in_use) begin
               mreq.wr_en   = 1'b1;
               mreq.wr_addr = wptr_ff[ffaa_pkg::IDX_W-1:0];
               wptr_in      = wptr_ff + 1'b1;
            end
            rptr_in  = rptr_ff + 1'b1;
            state_in = S_COMPACT;
         end
         S_SCAN: begin
            state_in = S_SCANCHK;
         end
         S_SCANCHK: begin
            // gap before entry rptr is [end_ff, start)
            if (end_ff + need_ff <= rd_start_w) begin
               wptr_in  = rptr_ff;
               carry_in = '{start: end_ff[ffaa_pkg::OFS_W-1:0],
                            length: need_ff[ffaa_pkg::LEN_W-1:0], in_use: 1'b1};
               ofs_in   = ffaa_pkg::OFS_W'(end_ff + Hdr);
               state_in = S_SHIFT;
            end else if (rptr_ff + 1'b1 >= count_ff) begin
               if (rd_end + need_ff <= Arena) begin
                  wptr_in  = count_ff;
                  carry_in = '{start: rd_end[ffaa_pkg::OFS_W-1:0],
                               length: need_ff[ffaa_pkg::LEN_W-1:0], in_use: 1'b1};
                  ofs_in   = ffaa_pkg::OFS_W'(rd_end + Hdr);
                  state_in = S_SHIFT;
               end else begin
                  st_in    = ffaa_pkg::ST_NOSPACE;
                  state_in = S_DONE;
               end
            end else begin
               end_in   = rd_end;
               rptr_in  = rptr_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SHIFT: begin
            // ripple entries up one slot: first the new entry, then the old one read last cycle
            mreq.rd_addr = wptr_ff[ffaa_pkg::IDX_W-1:0];
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = wptr_ff[ffaa_pkg::IDX_W-1:0];
            mreq.wr_data = shift_pending_ff ? rd_data : carry_ff;
            if (wptr_ff >= count_ff) begin
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               wptr_in  = wptr_ff + 1'b1;
               rptr_in  = wptr_ff;
               state_in = S_SHIFT;
            end
         end
         S_DONE: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
         shift_pending_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         shift_pending_ff <= (state_ff == S_SHIFT) && (state_in == S_SHIFT);
      end
      rptr_ff   <= rptr_in;
      wptr_ff   <= wptr_in;
      mode_ff   <= mode_in;
      need_ff   <= need_in;
      handle_ff <= handle_in;
      end_ff    <= end_in;
      ofs_ff    <= ofs_in;
      st_ff     <= st_in;
      carry_ff  <= carry_in;
   end

endmodule

FILE: rtl/first_fit_arena_allocator_top.sv
// top level of the first-fit arena allocator
// Each request takes one transfer on start while busy is low and returns exactly
// one result, marked by rsp_valid for one cycle; the receiver cannot stall it.
// A request may go through a lookup, compaction, the first-fit scan and the insertion
// ripple, each stepping through the table of at most 16 entries, and then posts
// the result; every step goes through the block table memory with its registered
// read port.
module first_fit_arena_allocator_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_mode,
   input  logic [7:0]                 req_req_size,
   input  logic [ffaa_pkg::OFS_W-1:0] req_handle,
   output logic                       rsp_valid,
   output logic [ffaa_pkg::OFS_W-1:0] rsp_payload_offset,
   output logic [1:0]                 rsp_status
);

   ffaa_pkg::mem_req_type mem_req;
   ffaa_pkg::entry_type   rd_data;

   ffaa_sequencer u_seq (
      .clock, .reset, .start,
      .req_mode, .req_req_size, .req_handle,
      .busy, .rsp_valid, .rsp_payload_offset, .rsp_status,
      .mem_req, .rd_data
   );

   ffaa_table_ram u_ram (
      .clock, .mem_req, .rd_data
   );

endmodule
